>>> rtl/csq_pkg.sv
`default_nettype none
// ============================================================================
// csq_pkg - shared types for the counting semaphore wait queue
// Holds the field widths, command and status codes, the back-end state
// encoding and the structures passed between the front end and the back end.
// ============================================================================
package csq_pkg;

    localparam int ID_W    = 8;
    localparam int INIT_W  = 8;
    localparam int COUNT_W = 9;
    localparam int STAT_W  = 3;

    typedef enum logic
    {
        CMD_DOWN = 1'b0,
        CMD_UP   = 1'b1
    } cmd_t;

    typedef enum logic [STAT_W-1:0]
    {
        ST_PROCEED   = 3'd0,
        ST_BLOCKED   = 3'd1,
        ST_WOKEN     = 3'd2,
        ST_FULL      = 3'd3,
        ST_EMPTY     = 3'd4,
        ST_SATURATED = 3'd5
    } status_t;

    typedef enum logic
    {
        BK_EXEC = 1'b0,
        BK_WAKE = 1'b1
    } back_state_t;

    typedef struct packed
    {
        cmd_t            cmd;
        logic [ID_W-1:0] tid;
    } op_t;

    typedef struct packed
    {
        status_t                    status;
        logic [ID_W-1:0]            woken;
        logic signed [COUNT_W-1:0]  count;
    } result_t;

    localparam logic signed [COUNT_W-1:0] COUNT_MAX = 9'sd255;
    localparam logic signed [COUNT_W-1:0] COUNT_MIN = 9'sh100;

endpackage : csq_pkg
`default_nettype wire

>>> rtl/csq_fifo.sv
`default_nettype none
// ============================================================================
// csq_fifo - two-entry queue
// A small first-in first-out buffer used between the front end and the back
// end, and again in front of the result ports.
// ============================================================================
module csq_fifo
#(
    parameter int WIDTH = 9
)
(
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             wr_en,
    input  wire logic [WIDTH-1:0] wr_data,
    output logic                  full,
    input  wire logic             rd_en,
    output logic [WIDTH-1:0]      rd_data,
    output logic                  empty
);

    logic [WIDTH-1:0] slot_reg [2];
    logic             wr_ptr_reg;
    logic             wr_ptr_next;
    logic             rd_ptr_reg;
    logic             rd_ptr_next;
    logic [1:0]       cnt_reg;
    logic [1:0]       cnt_next;
    logic             do_wr;
    logic             do_rd;

    assign full    = (cnt_reg == 2'd2);
    assign empty   = (cnt_reg == 2'd0);
    assign rd_data = slot_reg[rd_ptr_reg];
    assign do_wr   = wr_en && !full;
    assign do_rd   = rd_en && !empty;

    always_comb
    begin
        wr_ptr_next = do_wr ? ~wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = do_rd ? ~rd_ptr_reg : rd_ptr_reg;
        cnt_next    = cnt_reg;
        if (do_wr && !do_rd)
        begin
            cnt_next = cnt_reg + 2'd1;
        end
        else if (do_rd && !do_wr)
        begin
            cnt_next = cnt_reg - 2'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            cnt_reg    <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_wr)
        begin
            slot_reg[wr_ptr_reg] <= wr_data;
        end
    end

endmodule : csq_fifo
`default_nettype wire

>>> rtl/csq_front.sv
`default_nettype none
// ============================================================================
// csq_front - command intake
// Accepts operations from the push side, decodes the command and holds them
// in a short queue until the back end is ready to execute them.
// ============================================================================
module csq_front
(
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    input  wire logic                       push,
    output logic                            full,
    input  wire logic                       cmd,
    input  wire logic [csq_pkg::ID_W-1:0]   thread_id,
    output logic                            op_valid,
    output csq_pkg::op_t                    op,
    input  wire logic                       op_pop
);
    import csq_pkg::*;

    op_t              in_op;
    logic [$bits(op_t)-1:0] q_out;
    logic             q_empty;

    always_comb
    begin
        in_op.cmd = (cmd == 1'b1) ? CMD_UP : CMD_DOWN;
        in_op.tid = thread_id;
    end

    csq_fifo
    #(
        .WIDTH ($bits(op_t))
    )
    u_op_q
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (push),
        .wr_data (in_op),
        .full    (full),
        .rd_en   (op_pop),
        .rd_data (q_out),
        .empty   (q_empty)
    );

    assign op_valid = !q_empty;
    assign op       = op_t'(q_out);

endmodule : csq_front
`default_nettype wire

>>> rtl/csq_back.sv
`default_nettype none
// ============================================================================
// csq_back - semaphore execution unit
// Holds the semaphore count and the wait-id queue, executes one operation
// at a time and places each outcome in the result queue.
// ============================================================================
module csq_back
#(
    parameter int QUEUE_DEPTH = 16
)
(
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire logic                         cfg_wr,
    input  wire logic [csq_pkg::INIT_W-1:0]   cfg_data,
    input  wire logic                         op_valid,
    input  wire csq_pkg::op_t                 op,
    output logic                              op_pop,
    output csq_pkg::result_t                  res,
    output logic                              res_empty,
    input  wire logic                         res_pop
);
    import csq_pkg::*;

    localparam int PTR_W = $clog2(QUEUE_DEPTH);
    localparam int OCC_W = $clog2(QUEUE_DEPTH + 1);
    localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(QUEUE_DEPTH - 1);
    localparam logic [OCC_W-1:0] OCC_FULL = OCC_W'(QUEUE_DEPTH);

    logic [ID_W-1:0]           wait_mem [QUEUE_DEPTH];
    back_state_t               state_reg;
    back_state_t               state_next;
    logic signed [COUNT_W-1:0] count_reg;
    logic signed [COUNT_W-1:0] count_next;
    logic signed [COUNT_W-1:0] count_inc;
    logic signed [COUNT_W-1:0] wake_count_reg;
    logic signed [COUNT_W-1:0] wake_count_next;
    logic [PTR_W-1:0]          head_reg;
    logic [PTR_W-1:0]          head_next;
    logic [PTR_W-1:0]          tail_reg;
    logic [PTR_W-1:0]          tail_next;
    logic [OCC_W-1:0]          occ_reg;
    logic [OCC_W-1:0]          occ_next;
    logic [ID_W-1:0]           rd_data_reg;
    logic                      mem_we;
    logic                      mem_re;
    logic                      res_push;
    logic                      res_full;
    result_t                   res_in;
    logic [$bits(result_t)-1:0] res_q_out;

    assign count_inc = count_reg + 9'sd1;

    always_comb
    begin
        state_next      = state_reg;
        count_next      = count_reg;
        wake_count_next = wake_count_reg;
        head_next       = head_reg;
        tail_next       = tail_reg;
        occ_next        = occ_reg;
        mem_we          = 1'b0;
        mem_re          = 1'b0;
        op_pop          = 1'b0;
        res_push        = 1'b0;
        res_in.status   = ST_PROCEED;
        res_in.woken    = '0;
        res_in.count    = count_reg;

        if (cfg_wr)
        begin
            count_next = signed'({1'b0, cfg_data});
            head_next  = '0;
            tail_next  = '0;
            occ_next   = '0;
            state_next = BK_EXEC;
        end
        else
        begin
            case (state_reg)
                BK_EXEC:
                begin
                    if (op_valid && !res_full)
                    begin
                        op_pop = 1'b1;
                        case (op.cmd)
                            CMD_DOWN:
                            begin
                                res_push = 1'b1;
                                if (count_reg <= 9'sd0)
                                begin
                                    if ((occ_reg >= OCC_FULL) || (count_reg == COUNT_MIN))
                                    begin
                                        res_in.status = ST_FULL;
                                    end
                                    else
                                    begin
                                        mem_we        = 1'b1;
                                        tail_next     = (tail_reg == PTR_LAST) ? '0
                                                                             : tail_reg + 1'b1;
                                        occ_next      = occ_reg + 1'b1;
                                        count_next    = count_reg - 9'sd1;
                                        res_in.status = ST_BLOCKED;
                                    end
                                end
                                else
                                begin
                                    count_next = count_reg - 9'sd1;
                                end
                                res_in.count = count_next;
                            end
                            CMD_UP:
                            begin
                                if (count_reg == COUNT_MAX)
                                begin
                                    res_push      = 1'b1;
                                    res_in.status = ST_SATURATED;
                                end
                                else
                                begin
                                    count_next = count_inc;
                                    if (count_inc <= 9'sd0)
                                    begin
                                        if (occ_reg == '0)
                                        begin
                                            res_push      = 1'b1;
                                            res_in.status = ST_EMPTY;
                                        end
                                        else
                                        begin
                                            // The oldest id comes out of the wait store in the next cycle; the result
                                            // follows in the wake state once the result queue has room.
                                            mem_re          = 1'b1;
                                            head_next       = (head_reg == PTR_LAST) ? '0
                                                                                   : head_reg + 1'b1;
                                            occ_next        = occ_reg - 1'b1;
                                            wake_count_next = count_inc;
                                            state_next      = BK_WAKE;
                                        end
                                    end
                                    else
                                    begin
                                        res_push = 1'b1;
                                    end
                                end
                                res_in.count = count_next;
                            end
                            default:
                            begin
                                res_push = 1'b1;
                            end
                        endcase
                    end
                end
                BK_WAKE:
                begin
                    if (!res_full)
                    begin
                        res_push      = 1'b1;
                        res_in.status = ST_WOKEN;
                        res_in.woken  = rd_data_reg;
                        res_in.count  = wake_count_reg;
                        state_next    = BK_EXEC;
                    end
                end
                default:
                begin
                    state_next = BK_EXEC;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= BK_EXEC;
            count_reg <= '0;
            head_reg  <= '0;
            tail_reg  <= '0;
            occ_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            count_reg <= count_next;
            head_reg  <= head_next;
            tail_reg  <= tail_next;
            occ_reg   <= occ_next;
        end
    end

    always_ff @(posedge clk)
    begin
        wake_count_reg <= wake_count_next;
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            wait_mem[tail_reg] <= op.tid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (mem_re)
        begin
            rd_data_reg <= wait_mem[head_reg];
        end
    end

    csq_fifo
    #(
        .WIDTH ($bits(result_t))
    )
    u_res_q
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (res_push),
        .wr_data (res_in),
        .full    (res_full),
        .rd_en   (res_pop),
        .rd_data (res_q_out),
        .empty   (res_empty)
    );

    assign res = result_t'(res_q_out);

`ifndef SYNTHESIS
    a_occ_bound: assert property (@(posedge clk) disable iff (!rst_n)
        occ_reg <= OCC_FULL)
        else $error("wait queue occupancy beyond its depth");

    a_push_room: assert property (@(posedge clk) disable iff (!rst_n)
        res_push |-> !res_full)
        else $error("result written into a full result queue");

    a_wake_done: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == BK_WAKE && !res_full && !cfg_wr) |=> state_reg == BK_EXEC)
        else $error("wake result not issued when the result queue had room");

    a_block_occ: assert property (@(posedge clk) disable iff (!rst_n)
        (!cfg_wr && res_push && res_in.status == ST_BLOCKED)
            |=> occ_reg == $past(occ_reg) + 1'b1)
        else $error("blocked caller not added to the wait queue");

    a_wake_occ: assert property (@(posedge clk) disable iff (!rst_n)
        (!cfg_wr && mem_re) |=> (occ_reg == $past(occ_reg) - 1'b1) && state_reg == BK_WAKE)
        else $error("waiter release did not shrink the wait queue");
`endif

endmodule : csq_back
`default_nettype wire

>>> rtl/counting_semaphore_wait_queue.sv
`default_nettype none
// ============================================================================
// counting_semaphore_wait_queue - counting semaphore with a FIFO of waiters
// Top level: a front end that takes down and up requests, a back end that
// keeps the count and the wait-id queue, and a result queue.
// ============================================================================
// Each transaction on the push side is a down (cmd 0) or an up (cmd 1) from
// the given thread, and yields exactly one result transaction on the pop side,
// in order. A down that drives the count negative queues the caller's id and
// reports it as blocked; an up that leaves the count at or below zero releases
// the oldest waiter and returns its id. A down that cannot be queued (queue
// holding QUEUE_DEPTH ids, or count at -256) reports queue full, an up at a
// count of 255 reports saturation, and both leave the state untouched. The
// back end executes one operation per clock cycle while the result queue has
// room; an up that wakes a waiter also passes through the wake state, because
// the waiter's id is read from the wait store through its registered read
// port. A two-entry queue on each side lets requests be accepted while
// earlier results wait to be taken. Writing the configuration register loads
// the count with the new initial value and empties the wait queue; it may
// only be written while the block is idle, and the configuration channel is
// always ready. The wait store is not cleared at reset, since no entry is
// read before it is written.
// ============================================================================
module counting_semaphore_wait_queue
#(
    parameter int QUEUE_DEPTH = 16
)
(
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          push,
    output logic                               full,
    input  wire logic                          cmd,
    input  wire logic [csq_pkg::ID_W-1:0]      thread_id,
    output logic                               empty,
    input  wire logic                          pop,
    output logic [csq_pkg::STAT_W-1:0]         status,
    output logic [csq_pkg::ID_W-1:0]           woken_thread,
    output logic signed [csq_pkg::COUNT_W-1:0] count_after,
    input  wire logic                          cfg_valid,
    output logic                               cfg_ready,
    input  wire logic [csq_pkg::INIT_W-1:0]    cfg_data
);
    import csq_pkg::*;

    op_t     op;
    logic    op_valid;
    logic    op_pop;
    result_t res;

    // Configuration is only to be written while idle (the block does not enforce this), so it is always taken.
    assign cfg_ready = 1'b1;

    csq_front u_front
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .full      (full),
        .cmd       (cmd),
        .thread_id (thread_id),
        .op_valid  (op_valid),
        .op        (op),
        .op_pop    (op_pop)
    );

    csq_back
    #(
        .QUEUE_DEPTH (QUEUE_DEPTH)
    )
    u_back
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_wr    (cfg_valid && cfg_ready),
        .cfg_data  (cfg_data),
        .op_valid  (op_valid),
        .op        (op),
        .op_pop    (op_pop),
        .res       (res),
        .res_empty (empty),
        .res_pop   (pop)
    );

    // Result fields straight from the head of the result queue.
    assign status       = res.status;
    assign woken_thread = res.woken;
    assign count_after  = res.count;

endmodule : counting_semaphore_wait_queue
`default_nettype wire
